@@ hw/rtl/ttb_pkg.sv @@
// Shared types and constants for the triangle tangent basis block.
package ttb_pkg;

	localparam int unsigned UNIT_SHIFT = 14;
	localparam int unsigned MAG_BITS   = 30;
	localparam int unsigned EDGE_W     = 33;
	localparam int unsigned TEX_W      = 25;
	localparam int unsigned PROD_W     = EDGE_W + TEX_W;
	localparam int unsigned MAGV_W     = PROD_W;
	localparam int unsigned QUOT_W     = 15;
	localparam int unsigned REM_W      = 47;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [23:0] tex_u;
		logic signed [23:0] tex_v;
	} vertex_t;

	typedef struct packed {
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] tangent_z;
		logic signed [15:0] bitangent_x;
		logic signed [15:0] bitangent_y;
		logic signed [15:0] bitangent_z;
		logic               uv_nondegenerate;
	} basis_t;

	typedef logic signed [EDGE_W-1:0] edge_t;
	typedef logic signed [TEX_W-1:0]  tdelta_t;

	// One closed triangle, reduced to edge and texture deltas
	typedef struct packed {
		edge_t [2:0] e1;
		edge_t [2:0] e2;
		tdelta_t     s1;
		tdelta_t     t1;
		tdelta_t     s2;
		tdelta_t     t2;
	} tri_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DET_MUL,
		ST_DET_CHK,
		ST_VMUL,
		ST_VSUB,
		ST_SHIFT,
		ST_SQM,
		ST_SQA,
		ST_SQRT,
		ST_DIVI,
		ST_DIV,
		ST_DSTORE,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic pop;
		logic load_out;
	} back_ctl_t;

endpackage

@@ hw/rtl/ttb_front.sv @@
// Front end: collects vertices and forms edge and texture deltas per triangle.
module ttb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vtx_valid,
	output logic             vtx_stall,
	input  ttb_pkg::vertex_t vtx,
	input  logic             q_full,
	output logic             q_push,
	output ttb_pkg::tri_t    q_data
);
	import ttb_pkg::*;

	logic [1:0]         count_q;
	logic signed [31:0] hp_q [6];
	logic signed [23:0] ht_q [4];
	logic               accept;

	// Stall only when the closing vertex has nowhere to go
	assign vtx_stall = (count_q == 2'd2) && q_full;
	assign accept    = vtx_valid && !vtx_stall;
	assign q_push    = accept && (count_q == 2'd2);

	// Count vertices of the current triangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (accept) begin
			count_q <= (count_q == 2'd2) ? 2'd0 : count_q + 2'd1;
		end
	end

	// Hold the first two vertices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) hp_q[i] <= '0;
			for (int i = 0; i < 4; i++) ht_q[i] <= '0;
		end else if (accept && count_q != 2'd2) begin
			if (count_q[0]) begin
				hp_q[3] <= vtx.pos_x;
				hp_q[4] <= vtx.pos_y;
				hp_q[5] <= vtx.pos_z;
				ht_q[2] <= vtx.tex_u;
				ht_q[3] <= vtx.tex_v;
			end else begin
				hp_q[0] <= vtx.pos_x;
				hp_q[1] <= vtx.pos_y;
				hp_q[2] <= vtx.pos_z;
				ht_q[0] <= vtx.tex_u;
				ht_q[1] <= vtx.tex_v;
			end
		end
	end

	// Form the deltas of the closing triangle
	always_comb begin
		logic signed [31:0] p3 [3];
		p3[0] = vtx.pos_x;
		p3[1] = vtx.pos_y;
		p3[2] = vtx.pos_z;
		for (int i = 0; i < 3; i++) begin
			q_data.e1[i] = EDGE_W'(hp_q[3+i]) - EDGE_W'(hp_q[i]);
			q_data.e2[i] = EDGE_W'(p3[i]) - EDGE_W'(hp_q[i]);
		end
		q_data.s1 = TEX_W'(ht_q[2]) - TEX_W'(ht_q[0]);
		q_data.t1 = TEX_W'(ht_q[3]) - TEX_W'(ht_q[1]);
		q_data.s2 = TEX_W'(vtx.tex_u) - TEX_W'(ht_q[0]);
		q_data.t2 = TEX_W'(vtx.tex_v) - TEX_W'(ht_q[1]);
	end

endmodule

@@ hw/rtl/ttb_fifo.sv @@
// Short triangle queue between the front and back ends.
module ttb_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ttb_pkg::tri_t wdata,
	input  logic          pop,
	output ttb_pkg::tri_t rdata,
	output logic          full,
	output logic          empty
);
	import ttb_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	tri_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	// Store incoming triangles
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

@@ hw/rtl/ttb_back.sv @@
// Back end: determinant, raw vectors, iterative square root and division.
module ttb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  ttb_pkg::tri_t    q_data,
	output logic             q_pop,
	output logic             basis_valid,
	input  logic             basis_stall,
	output ttb_pkg::basis_t  basis
);
	import ttb_pkg::*;

	back_state_t state_q, state_d;
	back_ctl_t   ctl;

	tri_t                     tri_q;
	logic signed [PROD_W-1:0] pa_q, pb_q;
	logic                     det_neg_q, det_nz_q;
	logic                     vec_q;
	logic [1:0]               j_q;
	logic [MAGV_W-1:0]        mag_q [3];
	logic                     negc_q [3];
	logic [MAGV_W-1:0]        mx_q;
	logic [2*MAG_BITS-1:0]    sq_q;
	logic [63:0]              sum_q;
	logic [63:0]              rn_q, root_q;
	logic [4:0]               cnt_q;
	logic [REM_W-1:0]         rem_q;
	logic [QUOT_W-1:0]        quo_q;
	logic signed [15:0]       res_q [2][3];
	logic                     out_valid_q;
	basis_t                   out_q;

	// Shared multiplier operands
	logic signed [TEX_W-1:0]  ma_t, mb_t;
	logic signed [EDGE_W-1:0] ma_p, mb_p;
	logic signed [PROD_W:0]   diff;
	logic [MAGV_W-1:0]        mag_new;
	logic [63:0]              sbit, strial;
	logic [REM_W-1:0]         dtrial;
	logic [MAG_BITS-1:0]      mcur;
	logic [15:0]              qext;

	always_comb begin
		if (state_q == ST_DET_MUL) begin
			ma_t = tri_q.s1;
			ma_p = EDGE_W'(tri_q.t2);
			mb_t = tri_q.s2;
			mb_p = EDGE_W'(tri_q.t1);
		end else if (vec_q) begin
			ma_t = tri_q.s1;
			ma_p = tri_q.e2[j_q];
			mb_t = tri_q.s2;
			mb_p = tri_q.e1[j_q];
		end else begin
			ma_t = tri_q.t2;
			ma_p = tri_q.e1[j_q];
			mb_t = tri_q.t1;
			mb_p = tri_q.e2[j_q];
		end
	end

	assign diff    = (PROD_W+1)'(pa_q) - (PROD_W+1)'(pb_q);
	assign mag_new = diff[PROD_W] ? MAGV_W'(-diff) : MAGV_W'(diff);
	assign sbit    = 64'd1 << {cnt_q, 1'b0};
	assign strial  = root_q + sbit;
	assign dtrial  = REM_W'(root_q[31:0]) << cnt_q[3:0];
	assign mcur    = mag_q[j_q][MAG_BITS-1:0];
	assign qext    = {1'b0, quo_q};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (!q_empty) state_d = ST_DET_MUL;
			ST_DET_MUL: state_d = ST_DET_CHK;
			ST_DET_CHK: state_d = (diff == '0) ? ST_DONE : ST_VMUL;
			ST_VMUL:    state_d = ST_VSUB;
			ST_VSUB:    state_d = (j_q == 2'd2) ? ST_SHIFT : ST_VMUL;
			ST_SHIFT: begin
				if (mx_q == '0)
					state_d = vec_q ? ST_DONE : ST_VMUL;
				else if (mx_q[MAGV_W-1:MAG_BITS] == '0)
					state_d = ST_SQM;
			end
			ST_SQM:     state_d = ST_SQA;
			ST_SQA:     state_d = (j_q == 2'd2) ? ST_SQRT : ST_SQM;
			ST_SQRT:    if (cnt_q == '0) state_d = ST_DIVI;
			ST_DIVI:    state_d = ST_DIV;
			ST_DIV:     if (cnt_q == '0) state_d = ST_DSTORE;
			ST_DSTORE: begin
				if (j_q != 2'd2) state_d = ST_DIVI;
				else             state_d = vec_q ? ST_DONE : ST_VMUL;
			end
			ST_DONE:    if (!out_valid_q) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		ctl.pop      = (state_q == ST_IDLE) && !q_empty;
		ctl.load_out = (state_q == ST_DONE) && !out_valid_q;
	end

	assign q_pop = ctl.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Datapath sequencing
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				tri_q <= q_data;
				for (int v = 0; v < 2; v++)
					for (int c = 0; c < 3; c++) res_q[v][c] <= '0;
			end
			ST_DET_MUL, ST_VMUL: begin
				pa_q <= ma_t * ma_p;
				pb_q <= mb_t * mb_p;
			end
			ST_DET_CHK: begin
				det_neg_q <= diff[PROD_W];
				det_nz_q  <= (diff != '0);
				vec_q     <= 1'b0;
				j_q       <= 2'd0;
				mx_q      <= '0;
			end
			ST_VSUB: begin
				mag_q[j_q]  <= mag_new;
				negc_q[j_q] <= diff[PROD_W];
				if (mag_new > mx_q) mx_q <= mag_new;
				j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
			end
			ST_SHIFT: begin
				if (mx_q == '0) begin
					vec_q <= 1'b1;
					mx_q  <= '0;
				end else if (mx_q[MAGV_W-1:MAG_BITS] != '0) begin
					mx_q <= mx_q >> 1;
					for (int c = 0; c < 3; c++) mag_q[c] <= mag_q[c] >> 1;
				end else begin
					sum_q <= '0;
				end
			end
			ST_SQM: sq_q <= mcur * mcur;
			ST_SQA: begin
				sum_q <= sum_q + 64'(sq_q);
				if (j_q == 2'd2) begin
					rn_q   <= sum_q + 64'(sq_q);
					root_q <= '0;
					cnt_q  <= 5'd31;
					j_q    <= 2'd0;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
			ST_SQRT: begin
				if (rn_q >= strial) begin
					rn_q   <= rn_q - strial;
					root_q <= (root_q >> 1) + sbit;
				end else begin
					root_q <= root_q >> 1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
			ST_DIVI: begin
				rem_q <= (REM_W'(mcur) << UNIT_SHIFT) + REM_W'(root_q[31:1]);
				quo_q <= '0;
				cnt_q <= 5'(QUOT_W - 1);
			end
			ST_DIV: begin
				if (rem_q >= dtrial) begin
					rem_q <= rem_q - dtrial;
					quo_q[cnt_q[3:0]] <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
			ST_DSTORE: begin
				res_q[vec_q][j_q] <= (negc_q[j_q] != det_neg_q) ? -qext : qext;
				if (j_q != 2'd2) begin
					j_q <= j_q + 2'd1;
				end else begin
					j_q   <= 2'd0;
					vec_q <= 1'b1;
					mx_q  <= '0;
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!basis_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q.tangent_x        <= res_q[0][0];
			out_q.tangent_y        <= res_q[0][1];
			out_q.tangent_z        <= res_q[0][2];
			out_q.bitangent_x      <= res_q[1][0];
			out_q.bitangent_y      <= res_q[1][1];
			out_q.bitangent_z      <= res_q[1][2];
			out_q.uv_nondegenerate <= det_nz_q;
		end
	end

	assign basis_valid = out_valid_q;
	assign basis       = out_q;

endmodule

@@ hw/rtl/triangle_tangent_basis.sv @@
// From the closing vertex, a triangle passes through the triangle queue to the back end, whose
// shared sequencer works on one triangle at a time: the determinant, then per vector up to 27
// normalizing shifts, a 32-step square root and three 15-step divisions; a degenerate triangle
// goes straight from the determinant check to its result.
// The front takes vertices every cycle while the triangle queue has room.
// Reset (arst_n low) clears the vertex count, held vertices, queue and sequencer.
module triangle_tangent_basis #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vtx_valid,
	output logic             vtx_stall,
	input  ttb_pkg::vertex_t vtx,
	output logic             basis_valid,
	input  logic             basis_stall,
	output ttb_pkg::basis_t  basis
);
	import ttb_pkg::*;

	tri_t push_data, pop_data;
	logic push, pop, full, empty;

	ttb_front u_front (
		.clk, .arst_n, .vtx_valid, .vtx_stall, .vtx,
		.q_full(full), .q_push(push), .q_data(push_data)
	);

	ttb_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk, .arst_n, .push, .wdata(push_data), .pop,
		.rdata(pop_data), .full, .empty
	);

	ttb_back u_back (
		.clk, .arst_n, .q_empty(empty), .q_data(pop_data), .q_pop(pop),
		.basis_valid, .basis_stall, .basis
	);

endmodule

@@ hw/rtl/ttb_checker.sv @@
// Port-level checks for the triangle tangent basis block.
module ttb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             vtx_valid,
	input logic             vtx_stall,
	input ttb_pkg::vertex_t vtx,
	input logic             basis_valid,
	input logic             basis_stall,
	input ttb_pkg::basis_t  basis
);
	import ttb_pkg::*;

	// Hold a stalled result transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		basis_valid && basis_stall |=> basis_valid && $stable(basis))
		else $error("stalled result transaction changed");

	// Degenerate triangles give zero vectors
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		basis_valid && !basis.uv_nondegenerate |->
		basis.tangent_x == 0 && basis.tangent_y == 0 && basis.tangent_z == 0 &&
		basis.bitangent_x == 0 && basis.bitangent_y == 0 && basis.bitangent_z == 0)
		else $error("degenerate triangle gave nonzero vector");

	// Tangent and bitangent x components stay within one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		basis_valid |->
		basis.tangent_x >= -16384 && basis.tangent_x <= 16384 &&
		basis.bitangent_x >= -16384 && basis.bitangent_x <= 16384)
		else $error("component out of unit range");

	// No result is valid right after reset
	a_nofirst: assert property (@(posedge clk)
		!arst_n |=> !basis_valid)
		else $error("result right after reset");

endmodule

bind triangle_tangent_basis ttb_checker u_ttb_checker (.*);
